/* hdl/pbld_pkg.sv */
// Package for the partial body length deframer.
// Holds the transaction types, deframer state record and length header constants.
// No dependencies.
`default_nettype none

package pbld_pkg;

	localparam logic [7:0] LEN_TWO_BYTE_BASE  = 8'd192;
	localparam logic [7:0] LEN_PARTIAL_BASE   = 8'd224;
	localparam logic [7:0] LEN_FIVE_BYTE_MARK = 8'd255;
	localparam logic [2:0] HDR_LAST_POS       = 3'd5;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_TWO  = 2'd1,
		KIND_FIVE = 2'd2
	} pbld_kind_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_end;
	} pbld_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_payload;
		logic       body_end;
		logic       error_flag;
	} pbld_out_t;

	typedef struct packed {
		logic [2:0]  header_position;
		logic [31:0] remaining_count;
		logic        chunk_is_final;
		pbld_kind_t  header_kind;
		logic        body_open;
	} pbld_state_t;

endpackage

`default_nettype wire

/* hdl/pbld_parser.sv */
// Next-state and result logic of the deframer for one stream transaction.
// Depends on pbld_pkg.
`default_nettype none

module pbld_parser (
	input  pbld_pkg::pbld_state_t st,
	input  pbld_pkg::pbld_in_t    item,
	output pbld_pkg::pbld_state_t nxt,
	output logic                  emit,
	output pbld_pkg::pbld_out_t   res
);
	import pbld_pkg::*;

	logic [7:0]  c;
	logic        fin;
	logic [31:0] fin_len;
	logic [31:0] rem_dec;
	logic [31:0] five_len;
	logic [2:0]  pos_inc;
	logic        last;

	assign c        = item.in_byte;
	assign rem_dec  = st.remaining_count - 32'd1;
	assign five_len = {st.remaining_count[23:0], c};
	assign pos_inc  = st.header_position + 3'd1;
	assign last     = (rem_dec == 32'd0) && st.chunk_is_final;

	always_comb begin
		nxt     = st;
		emit    = 1'b0;
		res     = '0;
		fin     = 1'b0;
		fin_len = '0;
		if (item.stream_end) begin
			if (st.header_position != 3'd0 || st.remaining_count != 32'd0 || st.body_open) begin
				nxt            = '0;
				emit           = 1'b1;
				res.error_flag = 1'b1;
			end
		end else if (st.header_position == 3'd0 && st.remaining_count != 32'd0) begin
			nxt.remaining_count = rem_dec;
			if (last) begin
				nxt.chunk_is_final = 1'b0;
				nxt.body_open      = 1'b0;
			end
			emit           = 1'b1;
			res.out_byte   = c;
			res.is_payload = 1'b1;
			res.body_end   = last;
		end else if (st.header_position == 3'd0) begin
			nxt.body_open = 1'b1;
			if (c < LEN_TWO_BYTE_BASE) begin
				fin     = 1'b1;
				fin_len = {24'd0, c};
			end else if (c < LEN_PARTIAL_BASE) begin
				nxt.remaining_count = {19'd0, c[4:0], 8'd0};
				nxt.header_kind     = KIND_TWO;
				nxt.header_position = 3'd1;
			end else if (c == LEN_FIVE_BYTE_MARK) begin
				nxt.remaining_count = '0;
				nxt.header_kind     = KIND_FIVE;
				nxt.header_position = 3'd1;
			end else begin
				nxt.remaining_count = 32'd1 << c[4:0];
				nxt.chunk_is_final  = 1'b0;
			end
		end else begin
			case (st.header_kind)
				KIND_TWO: begin
					fin     = 1'b1;
					fin_len = st.remaining_count + {23'd0, {1'b0, c} + 9'(LEN_TWO_BYTE_BASE)};
				end
				KIND_FIVE: begin
					nxt.header_position = pos_inc;
					if (pos_inc >= HDR_LAST_POS) begin
						fin     = 1'b1;
						fin_len = five_len;
					end else begin
						nxt.remaining_count = five_len;
					end
				end
				default: begin
					nxt.header_position = '0;
					nxt.header_kind     = KIND_NONE;
					nxt.remaining_count = '0;
				end
			endcase
		end
		if (fin) begin
			nxt.header_position = '0;
			nxt.header_kind     = KIND_NONE;
			nxt.remaining_count = fin_len;
			nxt.chunk_is_final  = 1'b1;
			if (fin_len == 32'd0) begin
				nxt.chunk_is_final = 1'b0;
				nxt.body_open      = 1'b0;
				emit               = 1'b1;
				res.body_end       = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/partial_body_length_deframer_unit.sv */
// Top level of the partial body length deframer: input register, parser, result register.
// Depends on pbld_pkg and pbld_parser.
//
// Takes one stream byte (or an end-of-stream mark) per transaction on the byte channel and
// gives at most one result per transaction on the result channel: a payload byte, a body end
// mark for a zero-length final chunk, or an error when the stream ends inside a body. The
// block sustains one transaction per clock cycle while the result channel does not stall; an
// accepted byte waits in the input register, and the combinational parser step then updates
// the header/chunk state and writes the result register when the result stage advances.
// Backpressure on the result channel holds both registers and drops byte_ready only when
// both are full and the waiting result is not taken.
`default_nettype none

module partial_body_length_deframer_unit (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 byte_valid,
	output logic                byte_ready,
	input  pbld_pkg::pbld_in_t  byte_item,
	output logic                res_valid,
	input  wire                 res_ready,
	output pbld_pkg::pbld_out_t res_item
);
	import pbld_pkg::*;

	logic        valid_s1;
	pbld_in_t    item_s1;
	logic        valid_s2;
	pbld_out_t   res_s2;
	pbld_state_t state_q;
	pbld_state_t state_nxt;
	logic        emit;
	pbld_out_t   res_nxt;
	logic        advance;

	assign advance    = !valid_s2 || res_ready;
	assign byte_ready = !valid_s1 || advance;
	assign res_valid  = valid_s2;
	assign res_item   = res_s2;

	pbld_parser u_parser (
		.st   (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.emit (emit),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (byte_ready) begin
				valid_s1 <= byte_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1 && emit;
				if (valid_s1) begin
					state_q <= state_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready) begin
			item_s1 <= byte_item;
		end
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

endmodule

`default_nettype wire

/* hdl/pbld_checker.sv */
// Port-level checker for partial_body_length_deframer_unit, with its bind statement.
// Depends on pbld_pkg.
`default_nettype none

module pbld_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 byte_valid,
	input wire                 byte_ready,
	input pbld_pkg::pbld_in_t  byte_item,
	input wire                 res_valid,
	input wire                 res_ready,
	input pbld_pkg::pbld_out_t res_item
);
	import pbld_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_item))
		else $error("result changed while stalled");

	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(byte_valid && byte_ready, 2))
		else $error("result without a byte transaction two cycles earlier");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.error_flag |->
			!res_item.is_payload && !res_item.body_end && res_item.out_byte == 8'd0)
		else $error("error result carries payload or body end");

	a_marker_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.is_payload && !res_item.error_flag |->
			res_item.body_end && res_item.out_byte == 8'd0)
		else $error("non-payload result is not a body end mark");

endmodule

bind partial_body_length_deframer_unit pbld_checker u_pbld_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_valid (byte_valid),
	.byte_ready (byte_ready),
	.byte_item  (byte_item),
	.res_valid  (res_valid),
	.res_ready  (res_ready),
	.res_item   (res_item)
);

`default_nettype wire
